// ===== rtl/lzss_chain_match_finder_defines.svh =====
// assertion macros for the lzss chain match finder checker
// no dependencies; included by the checker file
`ifndef LZSS_CHAIN_MATCH_FINDER_DEFINES_SVH
`define LZSS_CHAIN_MATCH_FINDER_DEFINES_SVH

// same-cycle implication
`define LCMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lcmf_pkg.sv =====
// shared types and constants of the lzss chain match finder
// no dependencies
package lcmf_pkg;

    typedef enum logic [1:0] {
        CMD_INIT    = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_REPLACE = 2'd2,
        CMD_FIND    = 2'd3
    } cmd_t;

    localparam int BYTE_VALUES = 256;
    localparam logic [7:0] FILL_RESET = 8'd32;

endpackage

// ===== rtl/lcmf_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module lcmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/lzss_chain_match_finder.sv =====
// lzss match finder over per-byte-value chains of window positions
// depends on lcmf_pkg and lcmf_ram
//
// usage
//   s_* channel takes one command request: init, load lookahead byte,
//   replace window byte or find match. only find gives a result on m_*.
//   cfg_* writes fill_char, used by the next init and by the reset sweep.
// sequencing
//   after reset, and after each init, a sweep over max(WINDOW_DEPTH, 256)
//   entries rebuilds window, chains and heads; no request is taken meanwhile.
//   load: modulo steps in S_MOD, the last of which writes the lookahead ram.
//   replace: the unlink and append states, stepping through each chain entry
//   walked in the old and new chains (links ram port). find: lookahead and
//   head reads (S_F0-S_F2), then per candidate S_FR and S_FC for each byte
//   compared and S_FL for its link read. one request is worked on at a time.
// stalls
//   a finished result waits in the output register; the next request is
//   taken meanwhile, and a second result waits until m_tready frees it.
module lzss_chain_match_finder #(
    parameter int WINDOW_DEPTH    = 4096,
    parameter int LOOKAHEAD_DEPTH = 18,
    parameter int MIN_MATCH_LIMIT = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // window_index[11:0], lookahead_pos[16:12], byte_value[24:17], lookahead_len[29:25]
    input  logic [31:0] s_tdata,
    // command[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // match_length[4:0], match_offset[16:5]
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    import lcmf_pkg::*;

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int PW    = $clog2(WINDOW_DEPTH + 2);
    localparam int LAW   = $clog2(LOOKAHEAD_DEPTH);
    localparam int LENW  = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int CLR_N = (WINDOW_DEPTH > BYTE_VALUES) ? WINDOW_DEPTH : BYTE_VALUES;
    localparam int CW    = $clog2(CLR_N);
    localparam logic [PW-1:0] NULL_PTR = PW'(WINDOW_DEPTH + 1);
    localparam logic [PW-1:0] WD_P     = PW'(WINDOW_DEPTH);

    typedef enum logic [16:0] {
        S_CLEAR = 17'b00000000000000001,
        S_IDLE  = 17'b00000000000000010,
        S_MOD   = 17'b00000000000000100,
        S_U0    = 17'b00000000000001000,
        S_U1    = 17'b00000000000010000,
        S_U2    = 17'b00000000000100000,
        S_U3    = 17'b00000000001000000,
        S_A0    = 17'b00000000010000000,
        S_A1    = 17'b00000000100000000,
        S_A2    = 17'b00000001000000000,
        S_F0    = 17'b00000010000000000,
        S_F1    = 17'b00000100000000000,
        S_F2    = 17'b00001000000000000,
        S_FR    = 17'b00010000000000000,
        S_FC    = 17'b00100000000000000,
        S_FL    = 17'b01000000000000000,
        S_DONE  = 17'b10000000000000000
    } state_t;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [11:0]      idx_reg, idx_next;
    logic [4:0]       pos_reg, pos_next;
    logic [7:0]       val_reg, val_next;
    logic [LENW-1:0]  len_reg, len_next;
    logic [PW-1:0]    p_reg, p_next;
    logic [PW-1:0]    after_reg, after_next;
    logic [7:0]       b_reg, b_next;
    logic [LENW-1:0]  j_reg, j_next;
    logic [AW-1:0]    wa_reg, wa_next;
    logic [LAW-1:0]   la_reg, la_next;
    logic [LENW-1:0]  best_len_reg, best_len_next;
    logic [AW-1:0]    best_off_reg, best_off_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [7:0]       fill_reg, fill_next;
    logic             out_valid_reg, out_valid_next;
    logic [4:0]       out_len_reg, out_len_next;
    logic [11:0]      out_off_reg, out_off_next;

    logic             win_we;
    logic [AW-1:0]    win_addr;
    logic [7:0]       win_wdata, win_rdata;
    logic             lnk_we;
    logic [AW-1:0]    lnk_addr;
    logic [PW-1:0]    lnk_wdata, lnk_rdata;
    logic             hd_we;
    logic [7:0]       hd_addr;
    logic [PW-1:0]    hd_wdata, hd_rdata;
    logic             la_we;
    logic [LAW-1:0]   la_addr;
    logic [7:0]       la_wdata, la_rdata;

    logic [LENW-1:0]  cand_len;
    logic             cand_end;
    logic [PW-1:0]    idx_p;

    function automatic logic [AW-1:0] win_inc(input logic [AW-1:0] a);
        return (a == AW'(WINDOW_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [LAW-1:0] la_inc(input logic [LAW-1:0] a);
        return (a == LAW'(LOOKAHEAD_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    lcmf_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_win (
        .clk(clk), .we(win_we), .addr(win_addr), .wdata(win_wdata), .rdata(win_rdata)
    );
    lcmf_ram #(.WIDTH(PW), .DEPTH(WINDOW_DEPTH)) u_lnk (
        .clk(clk), .we(lnk_we), .addr(lnk_addr), .wdata(lnk_wdata), .rdata(lnk_rdata)
    );
    lcmf_ram #(.WIDTH(PW), .DEPTH(BYTE_VALUES)) u_hd (
        .clk(clk), .we(hd_we), .addr(hd_addr), .wdata(hd_wdata), .rdata(hd_rdata)
    );
    lcmf_ram #(.WIDTH(8), .DEPTH(LOOKAHEAD_DEPTH)) u_la (
        .clk(clk), .we(la_we), .addr(la_addr), .wdata(la_wdata), .rdata(la_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, out_off_reg, out_len_reg};
    assign idx_p     = PW'(idx_reg);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        len_next       = len_reg;
        p_next         = p_reg;
        after_next     = after_reg;
        b_next         = b_reg;
        j_next         = j_reg;
        wa_next        = wa_reg;
        la_next        = la_reg;
        best_len_next  = best_len_reg;
        best_off_next  = best_off_reg;
        cnt_next       = cnt_reg;
        fill_next      = (cfg_valid && cfg_ready) ? cfg_data : fill_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_len_next   = out_len_reg;
        out_off_next   = out_off_reg;
        win_we    = 1'b0;
        win_addr  = '0;
        win_wdata = val_reg;
        lnk_we    = 1'b0;
        lnk_addr  = '0;
        lnk_wdata = NULL_PTR;
        hd_we     = 1'b0;
        hd_addr   = '0;
        hd_wdata  = NULL_PTR;
        la_we     = 1'b0;
        la_addr   = '0;
        la_wdata  = val_reg;
        cand_len  = j_reg;
        cand_end  = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                if (32'(cnt_reg) < WINDOW_DEPTH)
                begin
                    win_we    = 1'b1;
                    win_addr  = AW'(cnt_reg);
                    win_wdata = fill_reg;
                    lnk_we    = 1'b1;
                    lnk_addr  = AW'(cnt_reg);
                    lnk_wdata = (32'(cnt_reg) == WINDOW_DEPTH - 1) ? NULL_PTR
                                                                  : PW'(cnt_reg) + 1'b1;
                end
                if (32'(cnt_reg) < BYTE_VALUES)
                begin
                    hd_we    = 1'b1;
                    hd_addr  = 8'(cnt_reg);
                    hd_wdata = (8'(cnt_reg) == fill_reg) ? '0 : NULL_PTR;
                end
                if (cnt_reg == CW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next      = cmd_t'(s_tuser);
                    idx_next      = s_tdata[11:0];
                    pos_next      = s_tdata[16:12];
                    val_next      = s_tdata[24:17];
                    len_next      = (32'(s_tdata[29:25]) > LOOKAHEAD_DEPTH)
                                    ? LENW'(LOOKAHEAD_DEPTH) : LENW'(s_tdata[29:25]);
                    best_len_next = '0;
                    best_off_next = '0;
                    cnt_next      = '0;
                    state_next    = (cmd_t'(s_tuser) == CMD_INIT) ? S_CLEAR : S_MOD;
                end
            end
            S_MOD:
            begin
                if (32'(pos_reg) >= LOOKAHEAD_DEPTH)
                begin
                    pos_next = pos_reg - 5'(LOOKAHEAD_DEPTH);
                end
                else if (32'(idx_reg) >= WINDOW_DEPTH)
                begin
                    idx_next = idx_reg - 12'(WINDOW_DEPTH);
                end
                else
                begin
                    unique case (cmd_reg)
                        CMD_LOAD:
                        begin
                            la_we      = 1'b1;
                            la_addr    = LAW'(pos_reg);
                            state_next = S_IDLE;
                        end
                        CMD_REPLACE:
                        begin
                            state_next = S_U0;
                        end
                        CMD_FIND:
                        begin
                            state_next = (32'(len_reg) <= MIN_MATCH_LIMIT) ? S_DONE : S_F0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_U0:
            begin
                win_addr   = AW'(idx_reg);
                lnk_addr   = AW'(idx_reg);
                state_next = S_U1;
            end
            S_U1:
            begin
                b_next     = win_rdata;
                after_next = lnk_rdata;
                lnk_we     = 1'b1;
                lnk_addr   = AW'(idx_reg);
                hd_addr    = win_rdata;
                state_next = S_U2;
            end
            S_U2:
            begin
                if (hd_rdata == idx_p)
                begin
                    hd_we      = 1'b1;
                    hd_addr    = b_reg;
                    hd_wdata   = after_reg;
                    state_next = S_A0;
                end
                else if (hd_rdata < WD_P)
                begin
                    p_next     = hd_rdata;
                    lnk_addr   = AW'(hd_rdata);
                    state_next = S_U3;
                end
                else
                begin
                    state_next = S_A0;
                end
            end
            S_U3:
            begin
                if (lnk_rdata == idx_p)
                begin
                    lnk_we     = 1'b1;
                    lnk_addr   = AW'(p_reg);
                    lnk_wdata  = after_reg;
                    state_next = S_A0;
                end
                else if (lnk_rdata < WD_P)
                begin
                    p_next   = lnk_rdata;
                    lnk_addr = AW'(lnk_rdata);
                end
                else
                begin
                    state_next = S_A0;
                end
            end
            S_A0:
            begin
                win_we     = 1'b1;
                win_addr   = AW'(idx_reg);
                hd_addr    = val_reg;
                state_next = S_A1;
            end
            S_A1:
            begin
                if (hd_rdata >= WD_P)
                begin
                    hd_we      = 1'b1;
                    hd_addr    = val_reg;
                    hd_wdata   = idx_p;
                    state_next = S_IDLE;
                end
                else
                begin
                    p_next     = hd_rdata;
                    lnk_addr   = AW'(hd_rdata);
                    state_next = S_A2;
                end
            end
            S_A2:
            begin
                if (lnk_rdata < WD_P)
                begin
                    p_next   = lnk_rdata;
                    lnk_addr = AW'(lnk_rdata);
                end
                else
                begin
                    lnk_we     = 1'b1;
                    lnk_addr   = AW'(p_reg);
                    lnk_wdata  = idx_p;
                    state_next = S_IDLE;
                end
            end
            S_F0:
            begin
                la_addr    = LAW'(pos_reg);
                state_next = S_F1;
            end
            S_F1:
            begin
                hd_addr    = la_rdata;
                state_next = S_F2;
            end
            S_F2:
            begin
                if (hd_rdata >= WD_P)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    p_next     = hd_rdata;
                    j_next     = LENW'(1);
                    wa_next    = win_inc(AW'(hd_rdata));
                    la_next    = la_inc(LAW'(pos_reg));
                    state_next = S_FR;
                end
            end
            S_FR:
            begin
                win_addr   = wa_reg;
                la_addr    = la_reg;
                state_next = S_FC;
            end
            S_FC:
            begin
                if (win_rdata == la_rdata)
                begin
                    if (j_reg + 1'b1 < len_reg)
                    begin
                        j_next     = j_reg + 1'b1;
                        wa_next    = win_inc(wa_reg);
                        la_next    = la_inc(la_reg);
                        state_next = S_FR;
                    end
                    else
                    begin
                        cand_len = j_reg + 1'b1;
                        cand_end = 1'b1;
                    end
                end
                else
                begin
                    cand_len = j_reg;
                    cand_end = 1'b1;
                end
                if (cand_end)
                begin
                    if (cand_len > best_len_reg)
                    begin
                        best_len_next = cand_len;
                        best_off_next = AW'(p_reg);
                    end
                    if (cand_len == len_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        lnk_addr   = AW'(p_reg);
                        state_next = S_FL;
                    end
                end
            end
            S_FL:
            begin
                if (lnk_rdata >= WD_P)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    p_next     = lnk_rdata;
                    j_next     = LENW'(1);
                    wa_next    = win_inc(AW'(lnk_rdata));
                    la_next    = la_inc(LAW'(pos_reg));
                    state_next = S_FR;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = 5'(best_len_reg);
                    out_off_next   = 12'(best_off_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cmd_reg       <= CMD_INIT;
            idx_reg       <= '0;
            pos_reg       <= '0;
            val_reg       <= '0;
            len_reg       <= '0;
            p_reg         <= '0;
            after_reg     <= '0;
            b_reg         <= '0;
            j_reg         <= '0;
            wa_reg        <= '0;
            la_reg        <= '0;
            best_len_reg  <= '0;
            best_off_reg  <= '0;
            cnt_reg       <= '0;
            fill_reg      <= FILL_RESET;
            out_valid_reg <= 1'b0;
            out_len_reg   <= '0;
            out_off_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            val_reg       <= val_next;
            len_reg       <= len_next;
            p_reg         <= p_next;
            after_reg     <= after_next;
            b_reg         <= b_next;
            j_reg         <= j_next;
            wa_reg        <= wa_next;
            la_reg        <= la_next;
            best_len_reg  <= best_len_next;
            best_off_reg  <= best_off_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            out_len_reg   <= out_len_next;
            out_off_reg   <= out_off_next;
        end
    end

endmodule

// ===== rtl/lcmf_checker.sv =====
// port-level checker for the lzss chain match finder, with its bind
// depends on lzss_chain_match_finder_defines.svh
`include "lzss_chain_match_finder_defines.svh"

module lcmf_checker #(
    parameter int LOOKAHEAD_DEPTH = 18
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    `LCMF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result changed while stalled")
    `LCMF_ASSERT_NOW(a_len_range, m_tvalid, 32'(m_tdata[4:0]) <= LOOKAHEAD_DEPTH,
        "match length out of range")
    `LCMF_ASSERT_NOW(a_zero_off, m_tvalid && (m_tdata[4:0] == 5'd0), m_tdata[16:5] == 12'd0,
        "empty match has nonzero offset")
    `LCMF_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready,
        "request taken while busy")

endmodule

bind lzss_chain_match_finder lcmf_checker #(
    .LOOKAHEAD_DEPTH(LOOKAHEAD_DEPTH)
) u_lcmf_checker (.*);

// ===== bench/lzss_chain_match_finder_test.sv =====
// self-checking bench for lzss_chain_match_finder: streams init, load, replace and find
// requests, predicts every match result and checks each one; depends on lcmf_pkg and the rtl
`timescale 1ns / 1ps

import lcmf_pkg::*;

typedef struct packed {
    cmd_t       command;
    logic [11:0] window_index;
    logic [4:0]  lookahead_pos;
    logic [7:0]  byte_value;
    logic [4:0]  lookahead_len;
} match_request_t;

class match_scoreboard;
    localparam int WIN = 4096;
    localparam int LA = 18;
    localparam int MIN_LEN = 2;
    localparam int NIL = WIN + 1;

    logic [7:0] window_mem [WIN];
    int         heads [BYTE_VALUES];
    int         links [WIN];
    logic [7:0] lookahead_mem [LA];
    logic [7:0] fill_char;
    logic [4:0] pending_len [$];
    logic [11:0] pending_off [$];
    int         failures;
    int         matched;
    int         finds;
    int         replaces;

    function new();
        fill_char = FILL_RESET;
        failures = 0;
        matched = 0;
        finds = 0;
        replaces = 0;
        rebuild_chains();
    endfunction

    function void rebuild_chains();
        for (int i = 0; i < WIN; i++)
        begin
            window_mem[i] = fill_char;
            links[i] = (i + 1 < WIN) ? i + 1 : NIL;
        end
        for (int i = 0; i < BYTE_VALUES; i++)
            heads[i] = NIL;
        heads[fill_char] = 0;
    endfunction

    function void unlink_position(int idx);
        int b;
        int after;
        int p;
        int steps;
        b = window_mem[idx];
        after = links[idx];
        steps = 0;
        links[idx] = NIL;
        if (heads[b] == idx)
        begin
            heads[b] = after;
            return;
        end
        p = heads[b];
        while (p < WIN && links[p] != idx && steps < WIN)
        begin
            p = links[p];
            steps++;
        end
        if (p < WIN && links[p] == idx)
            links[p] = after;
    endfunction

    function void append_position(int idx);
        int b;
        int p;
        int steps;
        b = window_mem[idx];
        steps = 0;
        links[idx] = NIL;
        p = heads[b];
        if (p >= WIN)
        begin
            heads[b] = idx;
            return;
        end
        while (links[p] < WIN && steps < WIN)
        begin
            p = links[p];
            steps++;
        end
        links[p] = idx;
    endfunction

    // longest match search; also reports how many candidates were walked
    function void search_match(int head, int len, output logic [4:0] best_len,
                               output logic [11:0] best_off, output int walked);
        logic [7:0] str [LA];
        int bl;
        int bo;
        int p;
        int j;
        bl = 0;
        bo = 0;
        walked = 0;
        if (len > LA)
            len = LA;
        if (len > MIN_LEN)
        begin
            for (int i = 0; i < len; i++)
                str[i] = lookahead_mem[(head + i) % LA];
            p = heads[str[0]];
            while (p < WIN && walked < WIN)
            begin
                j = 1;
                while (j < len && window_mem[(p + j) % WIN] == str[j])
                    j++;
                if (j > bl)
                begin
                    bl = j;
                    bo = p;
                end
                if (j == len)
                    break;
                p = links[p];
                walked++;
            end
        end
        best_len = bl[4:0];
        best_off = bo[11:0];
    endfunction

    function void note_request(match_request_t r);
        logic [4:0] bl;
        logic [11:0] bo;
        int walked;
        case (r.command)
            CMD_INIT: rebuild_chains();
            CMD_LOAD: lookahead_mem[r.lookahead_pos % LA] = r.byte_value;
            CMD_REPLACE:
            begin
                unlink_position(r.window_index);
                window_mem[r.window_index] = r.byte_value;
                append_position(r.window_index);
                replaces++;
            end
            default:
            begin
                search_match(r.lookahead_pos % LA, r.lookahead_len, bl, bo, walked);
                pending_len.push_back(bl);
                pending_off.push_back(bo);
                finds++;
            end
        endcase
    endfunction

    function void check_result(logic [23:0] data);
        logic [4:0] el;
        logic [11:0] eo;
        if (pending_len.size() == 0)
        begin
            $display("%0t: unexpected result len=%0d off=%0d", $time, data[4:0], data[16:5]);
            failures++;
            return;
        end
        el = pending_len.pop_front();
        eo = pending_off.pop_front();
        if (data[4:0] !== el)
        begin
            $display("%0t: match_length expected %0d actual %0d", $time, el, data[4:0]);
            failures++;
        end
        if (data[16:5] !== eo)
        begin
            $display("%0t: match_offset expected %0d actual %0d", $time, eo, data[16:5]);
            failures++;
        end
        if (el != 0)
            matched++;
    endfunction
endclass

module lzss_chain_match_finder_test;
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    match_scoreboard sb;
    int  sent;
    bit  quiet;
    logic [7:0] alphabet [4];

    lzss_chain_match_finder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(20, 200);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            m_tready <= (gap_len() == 0);
        end
    end

    task automatic send_request(cmd_t c, int idx, int pos, int val, int len);
        match_request_t r;
        int g;
        logic [4:0] bl;
        logic [11:0] bo;
        int walked;
        // keep finds cheap: a huge chain walk turns into a short lookahead
        if (c == CMD_FIND)
        begin
            sb.search_match(pos % 18, len, bl, bo, walked);
            if (walked > 300)
                len = $urandom_range(0, 2);
        end
        r.command = c;
        r.window_index = idx[11:0];
        r.lookahead_pos = pos[4:0];
        r.byte_value = val[7:0];
        r.lookahead_len = len[4:0];
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.command;
        s_tdata <= {2'b00, r.lookahead_len, r.byte_value, r.lookahead_pos, r.window_index};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(r);
        sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_len.size() != 0)
            @(posedge clk);
        repeat (10000) @(posedge clk);
    endtask

    task automatic write_fill(int v);
        cfg_valid <= 1'b1;
        cfg_data <= v[7:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.fill_char = v[7:0];
    endtask

    function automatic int pick_byte();
        int b;
        b = alphabet[$urandom_range(0, 3)];
        return b;
    endfunction

    task automatic string_sequence();
        int k;
        int base;
        int head;
        int str [18];
        int flen;
        k = $urandom_range(3, 18);
        base = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 300);
        for (int i = 0; i < k; i++)
        begin
            str[i] = pick_byte();
            if ($urandom_range(0, 2) != 0)
                send_request(CMD_REPLACE, (base + i) % 4096, $urandom_range(0, 31),
                             str[i], $urandom_range(0, 31));
        end
        head = $urandom_range(0, 17);
        for (int i = 0; i < k; i++)
            send_request(CMD_LOAD, $urandom_range(0, 4095),
                         ((head + i) % 18) + ((((head + i) % 18) < 14 && $urandom_range(0, 3) == 0)
                         ? 18 : 0),
                         ($urandom_range(0, 7) == 0) ? pick_byte() : str[i],
                         $urandom_range(0, 31));
        flen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : k;
        send_request(CMD_FIND, $urandom_range(0, 4095),
                     (head < 14 && $urandom_range(0, 1) == 0) ? head + 18 : head,
                     $urandom_range(0, 255), flen);
    endtask

    task automatic noise_request();
        int c;
        c = $urandom_range(1, 3);
        send_request(cmd_t'(c), $urandom_range(0, 4095), $urandom_range(0, 31),
                     $urandom_range(0, 255), $urandom_range(0, 31));
    endtask

    initial
    begin
        int fills [6];
        sb = new();
        sent = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_INIT;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: fill every lookahead slot, extremes, short and long finds
        for (int i = 0; i < 18; i++)
            send_request(CMD_LOAD, 0, (i < 4) ? i + 18 : i, (i == 0) ? 32 : (i * 15), 0);
        send_request(CMD_REPLACE, 0, 0, 255, 0);
        send_request(CMD_REPLACE, 4095, 31, 0, 31);
        send_request(CMD_REPLACE, 4095, 0, 0, 0);
        send_request(CMD_FIND, 0, 0, 0, 0);
        send_request(CMD_FIND, 0, 0, 0, 2);
        send_request(CMD_FIND, 0, 31, 0, 3);
        send_request(CMD_FIND, 0, 1, 0, 18);
        send_request(CMD_FIND, 0, 17, 0, 31);
        send_request(CMD_INIT, 0, 0, 0, 0);

        fills[0] = 0;
        fills[1] = 255;
        fills[2] = $urandom_range(1, 254);
        fills[3] = 32;
        fills[4] = $urandom_range(0, 255);
        fills[5] = $urandom_range(0, 255);
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            write_fill(fills[ph]);
            send_request(CMD_INIT, $urandom_range(0, 4095), $urandom_range(0, 31),
                         $urandom_range(0, 255), $urandom_range(0, 31));
            for (int a = 0; a < 4; a++)
                do
                    alphabet[a] = $urandom_range(0, 255);
                while (alphabet[a] == fills[ph]);
            quiet = (ph == 2);
            while (sent < 30 + (ph + 1) * 150)
                if ($urandom_range(0, 4) != 0)
                    string_sequence();
                else
                    noise_request();
        end

        wait_idle();
        $display("covered %0d requests: %0d finds (%0d nonzero), %0d replaces, 6 fill settings",
                 sent, sb.finds, sb.matched, sb.replaces);
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #400ms;
        $display("timeout");
        $display("Test completed with failures");
        $finish;
    end
endmodule
